### hdl/tcc_pkg.sv
// Shared constants, types and width helpers for the circumcenter core.
package tcc_pkg;

   localparam int OUT_W         = 32;  // width of one center coordinate
   localparam int Q_BITS        = 32;  // quotient bits produced by the divider chain
   localparam int WEIGHT_STAGES = 5;   // pipeline stages ahead of the divider chain

   // Per-lane status that rides along with the division.
   typedef struct packed {
      logic neg;   // quotient is negative
      logic big;   // quotient magnitude needs more than Q_BITS bits
      logic deg;   // weight sum or area term is zero
   } tcc_flag_type;

   // Width of the unsigned dividend handed to the divider chain.
   function automatic int rem_width(input int cw, input int rfb);
      int dotw;
      int ww;
      begin
         dotw = 2 * (cw + 1) + 2;
         ww   = dotw + dotw + 1;
         return ww + cw + 2 + rfb + 1;
      end
   endfunction

endpackage

### hdl/tcc_weight.sv
// Front pipeline: edge vectors, dot products, weights, numerators and dividend setup.
module tcc_weight #(
   parameter int CW  = 16,
   parameter int RFB = 16,
   parameter int ZW  = 128
) (
   input  logic                                clock,
   input  logic [tcc_pkg::WEIGHT_STAGES-1:0]   en,
   input  logic signed [CW-1:0]                a_x,
   input  logic signed [CW-1:0]                a_y,
   input  logic signed [CW-1:0]                a_z,
   input  logic signed [CW-1:0]                b_x,
   input  logic signed [CW-1:0]                b_y,
   input  logic signed [CW-1:0]                b_z,
   input  logic signed [CW-1:0]                c_x,
   input  logic signed [CW-1:0]                c_y,
   input  logic signed [CW-1:0]                c_z,
   output logic [ZW-1:0]                       rem_out [3],
   output logic [ZW-1:0]                       den_out,
   output tcc_pkg::tcc_flag_type               flag_out [3]
);

   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int DOTW = PW + 2;
   localparam int SW   = DOTW + 1;
   localparam int WW   = DOTW + SW;
   localparam int SUMW = WW + 2;
   localparam int NW   = WW + CW + 2;
   localparam int CFB  = CW / 2;
   localparam int QB   = tcc_pkg::Q_BITS;

   // stage 1: edge vectors and vertices
   logic signed [DW-1:0] ab_ff [3];
   logic signed [DW-1:0] ac_ff [3];
   logic signed [DW-1:0] bc_ff [3];
   logic signed [CW-1:0] v1_ff [3][3];
   // stage 2: dot products
   logic signed [DOTW-1:0] da_ff, db_ff, dc_ff;
   logic                   xz2_ff;
   logic signed [CW-1:0]   v2_ff [3][3];
   // stage 3: weights
   logic signed [WW-1:0]   wa_ff, wb_ff, wc_ff;
   logic                   xz3_ff;
   logic signed [CW-1:0]   v3_ff [3][3];
   // stage 4: weight sum and numerators
   logic signed [SUMW-1:0] ws_ff;
   logic signed [NW-1:0]   num_ff [3];
   logic                   xz4_ff;
   // stage 5 outputs
   logic [ZW-1:0]          rem_ff [3];
   logic [ZW-1:0]          den_ff;
   tcc_pkg::tcc_flag_type  flag_ff [3];

   logic signed [CW-1:0]   vin [3][3];
   logic signed [PW:0]     x_in;
   logic [ZW-1:0]          adn_in;

   assign vin[0][0] = a_x;
   assign vin[0][1] = a_y;
   assign vin[0][2] = a_z;
   assign vin[1][0] = b_x;
   assign vin[1][1] = b_y;
   assign vin[1][2] = b_z;
   assign vin[2][0] = c_x;
   assign vin[2][1] = c_y;
   assign vin[2][2] = c_z;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 3; k++) begin
            ab_ff[k] <= DW'(vin[1][k]) - DW'(vin[0][k]);
            ac_ff[k] <= DW'(vin[2][k]) - DW'(vin[0][k]);
            bc_ff[k] <= DW'(vin[2][k]) - DW'(vin[1][k]);
         end
         v1_ff <= vin;
      end
   end

   // area term only feeds the zero test
   assign x_in = (PW+1)'(PW'(ac_ff[0]) * PW'(ab_ff[1]))
               - (PW+1)'(PW'(ac_ff[1]) * PW'(ab_ff[0]));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         da_ff <= DOTW'(PW'(ab_ff[0]) * PW'(ac_ff[0])) + DOTW'(PW'(ab_ff[1]) * PW'(ac_ff[1]))
                + DOTW'(PW'(ab_ff[2]) * PW'(ac_ff[2]));
         db_ff <= -(DOTW'(PW'(ab_ff[0]) * PW'(bc_ff[0])) + DOTW'(PW'(ab_ff[1]) * PW'(bc_ff[1]))
                + DOTW'(PW'(ab_ff[2]) * PW'(bc_ff[2])));
         dc_ff <= DOTW'(PW'(bc_ff[0]) * PW'(ac_ff[0])) + DOTW'(PW'(bc_ff[1]) * PW'(ac_ff[1]))
                + DOTW'(PW'(bc_ff[2]) * PW'(ac_ff[2]));
         xz2_ff <= (x_in == '0);
         v2_ff  <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         wa_ff  <= WW'(da_ff) * WW'(SW'(db_ff) + SW'(dc_ff));
         wb_ff  <= WW'(db_ff) * WW'(SW'(da_ff) + SW'(dc_ff));
         wc_ff  <= WW'(dc_ff) * WW'(SW'(da_ff) + SW'(db_ff));
         xz3_ff <= xz2_ff;
         v3_ff  <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ws_ff <= SUMW'(wa_ff) + SUMW'(wb_ff) + SUMW'(wc_ff);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= NW'(wa_ff) * NW'(v3_ff[0][k]) + NW'(wb_ff) * NW'(v3_ff[1][k])
                       + NW'(wc_ff) * NW'(v3_ff[2][k]);
         end
         xz4_ff <= xz3_ff;
      end
   end

   // magnitude of the scaled denominator
   assign adn_in = ws_ff[SUMW-1] ? (ZW'(-ws_ff) << CFB) : (ZW'(ws_ff) << CFB);

   always_ff @(posedge clock) begin
      logic [ZW-1:0]    an;
      logic [ZW-1:0]    nn;
      logic [ZW+QB:0]   dshift;
      if (en[4]) begin
         for (int k = 0; k < 3; k++) begin
            an = num_ff[k][NW-1] ? (ZW'(-num_ff[k]) << RFB) : (ZW'(num_ff[k]) << RFB);
            nn = (an << 1) + adn_in;
            dshift = (ZW+QB+1)'(adn_in << 1) << QB;
            rem_ff[k]      <= nn;
            flag_ff[k].neg <= num_ff[k][NW-1] ^ ws_ff[SUMW-1];
            flag_ff[k].big <= ((ZW+QB+1)'(nn) >= dshift);
            flag_ff[k].deg <= xz4_ff || (ws_ff == '0);
         end
         den_ff <= adn_in << 1;
      end
   end

   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign flag_out = flag_ff;

endmodule

### hdl/tcc_div_cell.sv
// One restoring-division cell: resolves a single quotient bit and hands on the remainder.
module tcc_div_cell #(
   parameter int ZW    = 128,
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ZW-1:0]                 rem_in,
   input  logic [ZW-1:0]                 den_in,
   input  logic [tcc_pkg::Q_BITS-1:0]    quot_in,
   input  tcc_pkg::tcc_flag_type         flag_in,
   output logic [ZW-1:0]                 rem_out,
   output logic [ZW-1:0]                 den_out,
   output logic [tcc_pkg::Q_BITS-1:0]    quot_out,
   output tcc_pkg::tcc_flag_type         flag_out
);

   localparam int RW = ZW + tcc_pkg::Q_BITS + 1;

   logic [RW-1:0]                trial;
   logic [ZW-1:0]                rem_ff, den_ff;
   logic [tcc_pkg::Q_BITS-1:0]   quot_ff;
   tcc_pkg::tcc_flag_type        flag_ff;

   assign trial = RW'(rem_in) - (RW'(den_in) << SHIFT);

   always_ff @(posedge clock) begin
      if (en) begin
         // subtract when the shifted divisor fits
         rem_ff          <= trial[RW-1] ? rem_in : trial[ZW-1:0];
         quot_ff         <= quot_in
                          | (trial[RW-1] ? '0 : (tcc_pkg::Q_BITS'(1) << SHIFT));
         den_ff          <= den_in;
         flag_ff         <= flag_in;
      end
   end

   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quot_out = quot_ff;
   assign flag_out = flag_ff;

endmodule

### hdl/triangle_circumcenter_core.sv
// From input transfer to result: 5 arithmetic stages, 32 divider cells and 1 output
//   register; the first stage loads on the transfer edge.
// Throughput (no stall): one triangle per cycle; the 32-cell restoring divider chain
//   resolves one quotient bit per cell and every cell takes a new operand each cycle.
// Each stage moves on when the one after it is empty or moving, so bubbles collapse.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
module triangle_circumcenter_core #(
   parameter int COORD_WIDTH      = 16,
   parameter int RESULT_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_a_x,
   input  logic signed [COORD_WIDTH-1:0]       req_a_y,
   input  logic signed [COORD_WIDTH-1:0]       req_a_z,
   input  logic signed [COORD_WIDTH-1:0]       req_b_x,
   input  logic signed [COORD_WIDTH-1:0]       req_b_y,
   input  logic signed [COORD_WIDTH-1:0]       req_b_z,
   input  logic signed [COORD_WIDTH-1:0]       req_c_x,
   input  logic signed [COORD_WIDTH-1:0]       req_c_y,
   input  logic signed [COORD_WIDTH-1:0]       req_c_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tcc_pkg::OUT_W-1:0]    rsp_center_x,
   output logic signed [tcc_pkg::OUT_W-1:0]    rsp_center_y,
   output logic signed [tcc_pkg::OUT_W-1:0]    rsp_center_z,
   output logic                                rsp_degenerate,
   output logic                                rsp_saturated
);

   localparam int ZW   = tcc_pkg::rem_width(COORD_WIDTH, RESULT_FRAC_BITS);
   localparam int QB   = tcc_pkg::Q_BITS;
   localparam int WS   = tcc_pkg::WEIGHT_STAGES;
   localparam int OW   = tcc_pkg::OUT_W;
   localparam int NST  = WS + QB + 1;   // total stages including the output register

   // Stage valid bits and the ready ripple running back from the result side.
   logic [NST-1:0] vld_ff, vld_in;
   logic [NST-1:0] rdy;

   always_comb begin
      rdy[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int i = NST - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   // advance each valid bit when its stage loads
   always_comb begin
      vld_in = vld_ff;
      for (int i = 0; i < NST; i++) begin
         if (rdy[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the requester while the first stage is full and blocked
   assign req_stall = !rdy[0];

   // Front arithmetic: products, weights, numerators and dividend setup.
   logic [ZW-1:0]          rem_w  [QB+1][3];
   logic [ZW-1:0]          den_w  [QB+1][3];
   logic [QB-1:0]          quot_w [QB+1][3];
   tcc_pkg::tcc_flag_type  flag_w [QB+1][3];
   logic [ZW-1:0]          den0;

   tcc_weight #(
      .CW  (COORD_WIDTH),
      .RFB (RESULT_FRAC_BITS),
      .ZW  (ZW)
   ) u_weight (
      .clock    (clock),
      .en       (rdy[WS-1:0]),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_z      (req_a_z),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_z      (req_b_z),
      .c_x      (req_c_x),
      .c_y      (req_c_y),
      .c_z      (req_c_z),
      .rem_out  (rem_w[0]),
      .den_out  (den0),
      .flag_out (flag_w[0])
   );

   for (genvar k = 0; k < 3; k++) begin : g_lane_in
      assign den_w[0][k]  = den0;
      assign quot_w[0][k] = '0;
   end

   // Divider chain: cell j resolves quotient bit QB-1-j for each coordinate lane.
   for (genvar j = 0; j < QB; j++) begin : g_cell
      for (genvar k = 0; k < 3; k++) begin : g_lane
         tcc_div_cell #(
            .ZW    (ZW),
            .SHIFT (QB - 1 - j)
         ) u_cell (
            .clock    (clock),
            .en       (rdy[WS+j]),
            .rem_in   (rem_w[j][k]),
            .den_in   (den_w[j][k]),
            .quot_in  (quot_w[j][k]),
            .flag_in  (flag_w[j][k]),
            .rem_out  (rem_w[j+1][k]),
            .den_out  (den_w[j+1][k]),
            .quot_out (quot_w[j+1][k]),
            .flag_out (flag_w[j+1][k])
         );
      end
   end

   // Sign, saturate and register the result.
   logic [OW-1:0] ctr_in [3];
   logic [2:0]    sat_in;
   logic [OW-1:0] ctr_ff [3];
   logic          deg_ff, sat_ff;

   localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0] NEG_MIN = {1'b1, {(OW-1){1'b0}}};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ctr_in[k] = '0;
         sat_in[k] = 1'b0;
         if (!flag_w[QB][k].deg) begin
            if (!flag_w[QB][k].neg) begin
               if (flag_w[QB][k].big || quot_w[QB][k] > POS_MAX) begin
                  ctr_in[k] = POS_MAX;
                  sat_in[k] = 1'b1;
               end else begin
                  ctr_in[k] = quot_w[QB][k];
               end
            end else begin
               if (flag_w[QB][k].big || quot_w[QB][k] > NEG_MIN) begin
                  ctr_in[k] = NEG_MIN;
                  sat_in[k] = 1'b1;
               end else begin
                  ctr_in[k] = -quot_w[QB][k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NST-1]) begin
         ctr_ff <= ctr_in;
         deg_ff <= flag_w[QB][0].deg;
         sat_ff <= |sat_in;
      end
   end

   assign rsp_valid      = vld_ff[NST-1];
   assign rsp_center_x   = ctr_ff[0];
   assign rsp_center_y   = ctr_ff[1];
   assign rsp_center_z   = ctr_ff[2];
   assign rsp_degenerate = deg_ff;
   assign rsp_saturated  = sat_ff;

endmodule

### hdl/tcc_checker.sv
// Port-level checker for the circumcenter core, bound to the top level.
module tcc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tcc_pkg::OUT_W-1:0]        rsp_center_x,
   input logic [tcc_pkg::OUT_W-1:0]        rsp_center_y,
   input logic [tcc_pkg::OUT_W-1:0]        rsp_center_z,
   input logic                             rsp_degenerate,
   input logic                             rsp_saturated
);

   localparam logic [tcc_pkg::OUT_W-1:0] POS_MAX = {1'b0, {(tcc_pkg::OUT_W-1){1'b1}}};
   localparam logic [tcc_pkg::OUT_W-1:0] NEG_MIN = {1'b1, {(tcc_pkg::OUT_W-1){1'b0}}};

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_center_x) && $stable(rsp_center_y))
      else $error("stalled result dropped or changed");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_center_x == '0 && rsp_center_y == '0
         && rsp_center_z == '0 && !rsp_saturated)
      else $error("degenerate result carries a center");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_center_x == POS_MAX || rsp_center_x == NEG_MIN
         || rsp_center_y == POS_MAX || rsp_center_y == NEG_MIN
         || rsp_center_z == POS_MAX || rsp_center_z == NEG_MIN)
      else $error("saturated flag without a clipped coordinate");

endmodule

bind triangle_circumcenter_core tcc_checker u_tcc_checker (.*);
